// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared depth, widths, result codes and controller-to-datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CPS_RESET = 32'd62500000;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_EXPIRED = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic mul;
        logic sum;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== hdl/stq_ifs.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface stq_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] delay_sec;
    logic [15:0] tag;

    modport source (output valid, func, delay_sec, tag, input ready);
    modport sink   (input valid, func, delay_sec, tag, output ready);
endinterface

interface stq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [63:0] out_deadline;
    logic        armed;

    modport source (output valid, status, out_tag, out_deadline, armed, input ready);
    modport sink   (input valid, status, out_tag, out_deadline, armed, output ready);
endinterface

interface stq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue controller
// One-hot sequencer: capture, multiply, sum, commit, then hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output stq_pkg::t_dp_cmd     o_cmd
);
    import stq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_rsp_valid   = (r_state == S_OUT);
    assign o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.mul     = (r_state == S_MUL);
    assign o_cmd.sum     = (r_state == S_SUM);
    assign o_cmd.commit  = (r_state == S_UPD);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rsp_valid && o_req_ready))
        else $error("request taken while a response is pending");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> o_cmd.mul)
        else $error("accepted transaction did not start the multiply");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_rsp_valid)
        else $error("commit not followed by a response");

endmodule

`default_nettype wire

// ===== hdl/stq_dpath.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue datapath
// Tick counter, deadline multiply-add and a sorted shift array of entries.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire stq_pkg::t_dp_cmd  i_cmd,
    input  wire logic              i_req_func,
    input  wire logic [31:0]       i_req_delay_sec,
    input  wire logic [15:0]       i_req_tag,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_data,
    output stq_pkg::t_status       o_status,
    output logic [15:0]            o_tag,
    output logic [63:0]            o_deadline,
    output logic                   o_armed
);
    import stq_pkg::*;

    logic [31:0]      r_cps;
    logic [63:0]      r_now;
    logic [CNT_W-1:0] r_count;
    logic             r_func;
    logic [31:0]      r_delay;
    logic [15:0]      r_tag;
    logic [63:0]      r_prod;
    logic [63:0]      r_deadline;
    logic [63:0]      r_dl [QUEUE_DEPTH];
    logic [15:0]      r_tg [QUEUE_DEPTH];
    t_status          r_status;
    logic [15:0]      r_otag;
    logic [63:0]      r_odl;
    logic             r_armed;

    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] prev_le;
    logic                   full;
    logic                   due;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CNT_W'(i) < r_count) && (r_dl[i] <= r_deadline);
        end
        prev_le[0] = 1'b1;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            prev_le[i] = le[i-1];
        end
    end

    assign full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign due  = (r_count != '0) && (r_dl[0] <= r_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps   <= CPS_RESET;
            r_now   <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cps <= i_cfg_data;
            end
            if (i_cmd.mul && r_func) begin
                r_now <= r_now + 64'd1;
            end
            if (i_cmd.commit) begin
                if (!r_func) begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end else if (due) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_req_func;
            r_delay <= i_req_delay_sec;
            r_tag   <= i_req_tag;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_delay) * 64'(r_cps);
        end
        if (i_cmd.sum) begin
            r_deadline <= r_prod + r_now;
        end
        if (i_cmd.commit) begin
            if (!r_func) begin
                r_otag  <= r_tag;
                r_odl   <= r_deadline;
                r_armed <= 1'b1;
                if (full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_ADDED;
                    if (!le[0] && prev_le[0]) begin
                        r_dl[0] <= r_deadline;
                        r_tg[0] <= r_tag;
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++) begin
                        if (!le[i]) begin
                            if (prev_le[i]) begin
                                r_dl[i] <= r_deadline;
                                r_tg[i] <= r_tag;
                            end else begin
                                r_dl[i] <= r_dl[i-1];
                                r_tg[i] <= r_tg[i-1];
                            end
                        end
                    end
                end
            end else if (due) begin
                r_status <= ST_EXPIRED;
                r_otag   <= r_tg[0];
                r_odl    <= r_dl[0];
                r_armed  <= (r_count > CNT_W'(1));
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    r_dl[i] <= r_dl[i+1];
                    r_tg[i] <= r_tg[i+1];
                end
            end else begin
                r_status <= ST_NONE;
                r_otag   <= '0;
                r_odl    <= '0;
                r_armed  <= (r_count != '0);
            end
        end
    end

    assign o_status   = r_status;
    assign o_tag      = r_otag;
    assign o_deadline = r_odl;
    assign o_armed    = r_armed;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_dl[0] <= r_dl[1]))
        else $error("queue head out of order");

endmodule

`default_nettype wire

// ===== hdl/sorted_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue
// One-shot timer queue with ascending deadlines, add and tick transactions.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake    Payload
//  i_req    in   valid/ready  func, delay_sec, tag
//  o_rsp    out  valid/ready  status, out_tag, out_deadline, armed
//  i_cfg    in   valid/ready  data (cycles_per_second), ready always high
//
//  Each transaction passes from acceptance to a valid response through the
//  multiply, deadline sum, queue commit, then the response register.
//  The next request is taken in the cycle after the response is taken,
//  so only one transaction is in flight at a time.
//  Synchronous active-low reset clears the counter, count and sequencer.
//  A stalled response holds the queue; no request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stq_cfg_if.sink    i_cfg,
    stq_req_if.sink    i_req,
    stq_rsp_if.source  o_rsp
);
    import stq_pkg::*;

    t_dp_cmd cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    stq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    stq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_func      (i_req.func),
        .i_req_delay_sec (i_req.delay_sec),
        .i_req_tag       (i_req.tag),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .o_status        (status),
        .o_tag           (o_rsp.out_tag),
        .o_deadline      (o_rsp.out_deadline),
        .o_armed         (o_rsp.armed)
    );

    assign o_rsp.status = status;

endmodule

`default_nettype wire
